// File: rtl/core/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// Shared widths, codes and helpers for the circular deque engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cde_pkg;

    localparam int DEPTH  = 128;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);

    localparam int CMD_W  = 4;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int FILL_W = 8;

    localparam int S_TDATA_W = ((CMD_W + WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + STAT_W + FILL_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [OCC_W-1:0]         occ_t;
    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_PEEK_FRONT = 4'd4,
        CMD_PEEK_BACK  = 4'd5,
        CMD_CLEAR      = 4'd6,
        CMD_REVERSE    = 4'd7,
        CMD_SORT       = 4'd8
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_PUSH,
        DP_READ,
        DP_CLEAR,
        DP_OTHER,
        DP_REV_INIT,
        DP_REV_RD_I,
        DP_REV_RD_J,
        DP_REV_WR_I,
        DP_REV_WR_J,
        DP_SORT_INIT,
        DP_SORT_RD0,
        DP_SORT_RD1,
        DP_SORT_CMP,
        DP_SORT_END,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic rev_done;
        logic sort_done;
        logic sort_more;
    } dp_stat_t;

    function automatic idx_t idx_inc(input idx_t i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cde_ram.sv
// ----------------------------------------------------------------------------
// cde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cde_dp.sv
// ----------------------------------------------------------------------------
// cde_dp
// Deque datapath: indices, occupancy, word store, swap/sort registers and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire cde_pkg::dp_op_t                op,
    input  wire cde_pkg::cmd_t                  in_cmd,
    input  wire cde_pkg::word_t                 in_value,
    output cde_pkg::dp_stat_t                   stat,
    output logic [cde_pkg::M_TDATA_W-1:0]       out_data
);

    cde_pkg::idx_t    head_reg, head_next;
    cde_pkg::idx_t    tail_reg, tail_next;
    cde_pkg::occ_t    occ_reg, occ_next;
    cde_pkg::idx_t    wa_reg, wa_next;
    cde_pkg::idx_t    rp_reg, rp_next;
    cde_pkg::occ_t    pos_reg, pos_next;
    cde_pkg::occ_t    lim_reg, lim_next;
    cde_pkg::word_t   carry_reg, carry_next;
    cde_pkg::word_t   item_reg, item_next;
    cde_pkg::status_t status_reg, status_next;
    logic             from_ram_reg, from_ram_next;
    logic [cde_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                         ram_we;
    cde_pkg::idx_t                ram_waddr;
    logic [cde_pkg::WORD_W-1:0]   ram_wdata;
    logic                         ram_re;
    cde_pkg::idx_t                ram_raddr;
    logic [cde_pkg::WORD_W-1:0]   ram_rdata;
    cde_pkg::word_t               rd_word;

    logic full, empty, front, is_pop, carry_gt, sort_more;
    cde_pkg::word_t item_sel;

    cde_ram #(
        .WIDTH (cde_pkg::WORD_W),
        .DEPTH (cde_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_word   = ram_rdata;
    assign full      = (occ_reg == cde_pkg::OCC_W'(cde_pkg::DEPTH));
    assign empty     = (occ_reg == '0);
    assign front     = (in_cmd == cde_pkg::CMD_PUSH_FRONT) || (in_cmd == cde_pkg::CMD_POP_FRONT)
                    || (in_cmd == cde_pkg::CMD_PEEK_FRONT);
    assign is_pop    = (in_cmd == cde_pkg::CMD_POP_FRONT) || (in_cmd == cde_pkg::CMD_POP_BACK);
    assign carry_gt  = (carry_reg > rd_word);
    assign sort_more = ((pos_reg + cde_pkg::OCC_W'(1)) != lim_reg);
    assign item_sel  = from_ram_reg ? rd_word : item_reg;

    assign stat.rev_done  = (pos_reg == (occ_reg >> 1));
    assign stat.sort_done = (lim_reg == '0);
    assign stat.sort_more = sort_more;
    assign out_data       = out_data_reg;

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        wa_next       = wa_reg;
        rp_next       = rp_reg;
        pos_next      = pos_reg;
        lim_next      = lim_reg;
        carry_next    = carry_reg;
        item_next     = item_reg;
        status_next   = status_reg;
        from_ram_next = from_ram_reg;
        out_data_next = out_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = wa_reg;
        ram_wdata     = carry_reg;
        ram_re        = 1'b0;
        ram_raddr     = wa_reg;

        unique case (op)
            cde_pkg::DP_NOP: begin
            end
            cde_pkg::DP_PUSH: begin
                item_next     = '0;
                from_ram_next = 1'b0;
                if (full) begin
                    status_next = cde_pkg::ST_OVERFLOW;
                end else begin
                    status_next = cde_pkg::ST_OK;
                    ram_we      = 1'b1;
                    ram_wdata   = in_value;
                    occ_next    = occ_reg + cde_pkg::OCC_W'(1);
                    if (empty) begin
                        head_next = '0;
                        tail_next = '0;
                        ram_waddr = '0;
                    end else if (front) begin
                        head_next = cde_pkg::idx_dec(head_reg);
                        ram_waddr = cde_pkg::idx_dec(head_reg);
                    end else begin
                        tail_next = cde_pkg::idx_inc(tail_reg);
                        ram_waddr = cde_pkg::idx_inc(tail_reg);
                    end
                end
            end
            cde_pkg::DP_READ: begin
                if (empty) begin
                    item_next     = '1;
                    status_next   = cde_pkg::ST_EMPTY;
                    from_ram_next = 1'b0;
                end else begin
                    status_next   = cde_pkg::ST_OK;
                    from_ram_next = 1'b1;
                    ram_re        = 1'b1;
                    ram_raddr     = front ? head_reg : tail_reg;
                    if (is_pop) begin
                        occ_next = occ_reg - cde_pkg::OCC_W'(1);
                        if (occ_reg > cde_pkg::OCC_W'(1)) begin
                            if (front) begin
                                head_next = cde_pkg::idx_inc(head_reg);
                            end else begin
                                tail_next = cde_pkg::idx_dec(tail_reg);
                            end
                        end
                    end
                end
            end
            cde_pkg::DP_CLEAR: begin
                head_next     = '0;
                tail_next     = '0;
                occ_next      = '0;
                item_next     = '0;
                status_next   = cde_pkg::ST_OK;
                from_ram_next = 1'b0;
            end
            cde_pkg::DP_OTHER: begin
                item_next     = '0;
                status_next   = cde_pkg::ST_OK;
                from_ram_next = 1'b0;
            end
            cde_pkg::DP_REV_INIT: begin
                item_next     = '0;
                status_next   = cde_pkg::ST_OK;
                from_ram_next = 1'b0;
                wa_next       = head_reg;
                rp_next       = tail_reg;
                pos_next      = '0;
            end
            cde_pkg::DP_REV_RD_I: begin
                ram_re    = 1'b1;
                ram_raddr = wa_reg;
            end
            cde_pkg::DP_REV_RD_J: begin
                carry_next = rd_word;
                ram_re     = 1'b1;
                ram_raddr  = rp_reg;
            end
            cde_pkg::DP_REV_WR_I: begin
                ram_we    = 1'b1;
                ram_waddr = wa_reg;
                ram_wdata = rd_word;
            end
            cde_pkg::DP_REV_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = rp_reg;
                ram_wdata = carry_reg;
                wa_next   = cde_pkg::idx_inc(wa_reg);
                rp_next   = cde_pkg::idx_dec(rp_reg);
                pos_next  = pos_reg + cde_pkg::OCC_W'(1);
            end
            cde_pkg::DP_SORT_INIT: begin
                item_next     = '0;
                status_next   = cde_pkg::ST_OK;
                from_ram_next = 1'b0;
                lim_next      = empty ? '0 : occ_reg - cde_pkg::OCC_W'(1);
            end
            cde_pkg::DP_SORT_RD0: begin
                ram_re    = 1'b1;
                ram_raddr = head_reg;
                wa_next   = head_reg;
                rp_next   = cde_pkg::idx_inc(head_reg);
                pos_next  = '0;
            end
            cde_pkg::DP_SORT_RD1: begin
                carry_next = rd_word;
                ram_re     = 1'b1;
                ram_raddr  = rp_reg;
                rp_next    = cde_pkg::idx_inc(rp_reg);
            end
            cde_pkg::DP_SORT_CMP: begin
                // larger word travels on, smaller one settles
                ram_we     = 1'b1;
                ram_waddr  = wa_reg;
                ram_wdata  = carry_gt ? rd_word : carry_reg;
                carry_next = carry_gt ? carry_reg : rd_word;
                wa_next    = cde_pkg::idx_inc(wa_reg);
                pos_next   = pos_reg + cde_pkg::OCC_W'(1);
                if (sort_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = rp_reg;
                    rp_next   = cde_pkg::idx_inc(rp_reg);
                end
            end
            cde_pkg::DP_SORT_END: begin
                ram_we    = 1'b1;
                ram_waddr = wa_reg;
                ram_wdata = carry_reg;
                lim_next  = lim_reg - cde_pkg::OCC_W'(1);
            end
            cde_pkg::DP_EMIT: begin
                out_data_next = cde_pkg::M_TDATA_W'({cde_pkg::FILL_W'(occ_reg),
                                                     status_reg, item_sel});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        wa_reg       <= wa_next;
        rp_reg       <= rp_next;
        pos_reg      <= pos_next;
        lim_reg      <= lim_next;
        carry_reg    <= carry_next;
        item_reg     <= item_next;
        status_reg   <= status_next;
        from_ram_reg <= from_ram_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/cde_ctrl.sv
// ----------------------------------------------------------------------------
// cde_ctrl
// Deque controller: command decode, reverse and sort sequencing, output
// handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire cde_pkg::cmd_t     in_cmd,
    input  wire cde_pkg::dp_stat_t stat,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output cde_pkg::dp_op_t        op
);

    typedef enum logic [3:0] {
        IDLE,
        REV_RD_I,
        REV_RD_J,
        REV_WR_I,
        REV_WR_J,
        SORT_PASS,
        SORT_RD1,
        SORT_CMP,
        SORT_END,
        FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        op         = cde_pkg::DP_NOP;

        if (m_tready) begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    state_next = FINISH;
                    unique case (in_cmd) inside
                        cde_pkg::CMD_PUSH_FRONT, cde_pkg::CMD_PUSH_BACK: begin
                            op = cde_pkg::DP_PUSH;
                        end
                        cde_pkg::CMD_POP_FRONT, cde_pkg::CMD_POP_BACK,
                        cde_pkg::CMD_PEEK_FRONT, cde_pkg::CMD_PEEK_BACK: begin
                            op = cde_pkg::DP_READ;
                        end
                        cde_pkg::CMD_CLEAR: begin
                            op = cde_pkg::DP_CLEAR;
                        end
                        cde_pkg::CMD_REVERSE: begin
                            op         = cde_pkg::DP_REV_INIT;
                            state_next = REV_RD_I;
                        end
                        cde_pkg::CMD_SORT: begin
                            op         = cde_pkg::DP_SORT_INIT;
                            state_next = SORT_PASS;
                        end
                        default: begin
                            op = cde_pkg::DP_OTHER;
                        end
                    endcase
                end
            end
            REV_RD_I: begin
                if (stat.rev_done) begin
                    state_next = FINISH;
                end else begin
                    op         = cde_pkg::DP_REV_RD_I;
                    state_next = REV_RD_J;
                end
            end
            REV_RD_J: begin
                op         = cde_pkg::DP_REV_RD_J;
                state_next = REV_WR_I;
            end
            REV_WR_I: begin
                op         = cde_pkg::DP_REV_WR_I;
                state_next = REV_WR_J;
            end
            REV_WR_J: begin
                op         = cde_pkg::DP_REV_WR_J;
                state_next = REV_RD_I;
            end
            SORT_PASS: begin
                if (stat.sort_done) begin
                    state_next = FINISH;
                end else begin
                    op         = cde_pkg::DP_SORT_RD0;
                    state_next = SORT_RD1;
                end
            end
            SORT_RD1: begin
                op         = cde_pkg::DP_SORT_RD1;
                state_next = SORT_CMP;
            end
            SORT_CMP: begin
                op = cde_pkg::DP_SORT_CMP;
                if (!stat.sort_more) begin
                    state_next = SORT_END;
                end
            end
            SORT_END: begin
                op         = cde_pkg::DP_SORT_END;
                state_next = SORT_PASS;
            end
            FINISH: begin
                if (!valid_reg || m_tready) begin
                    op         = cde_pkg::DP_EMIT;
                    valid_next = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/circular_deque_engine.sv
// ----------------------------------------------------------------------------
// circular_deque_engine
// Double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transaction: push or pop at either
//   end, peek at either end, clear, reverse, sort. Master stream returns one
//   result per command: item, status and fill.
//   Push, pop, peek, clear and unused codes: the command is worked on as it
//   is accepted, then FINISH loads the result register and raises m_tvalid;
//   s_tready returns with m_tvalid, so no new command is taken until the last is done.
//   Reverse of n words: floor(n/2) swaps, working inward from both ends;
//   each swap costs four store accesses through the single read and single
//   write port.
//   Sort of n words: bubble passes, one compare per cycle; a pass reads the
//   first two words, writes the smaller word back per compare and ends by
//   writing the last carried word; fewer than two words need no pass.
//   Reset clears indices, occupancy, controller state and the result valid
//   flag; store contents are not cleared and are only read once written.
//   A result waits in the output register while the master stalls; one more
//   command is accepted and worked on, then input stalls until the result
//   is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cde_pkg::S_TDATA_W-1:0] s_tdata,   // command, value
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [cde_pkg::M_TDATA_W-1:0] m_tdata    // item, status, fill
);

    cde_pkg::cmd_t     in_cmd;
    cde_pkg::word_t    in_value;
    cde_pkg::dp_op_t   op;
    cde_pkg::dp_stat_t stat;

    assign in_cmd   = cde_pkg::cmd_t'(s_tdata[cde_pkg::CMD_W-1:0]);
    assign in_value = s_tdata[cde_pkg::CMD_W +: cde_pkg::WORD_W];

    cde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (in_cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .op       (op)
    );

    cde_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .in_cmd   (in_cmd),
        .in_value (in_value),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/cde_checker.sv
// ----------------------------------------------------------------------------
// cde_checker
// Port-level checks for the circular deque engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [cde_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cde_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ITEM_W = cde_pkg::WORD_W;
    localparam int STAT_LO = ITEM_W;
    localparam int FILL_LO = ITEM_W + cde_pkg::STAT_W;

    logic [ITEM_W-1:0]          out_item;
    logic [cde_pkg::STAT_W-1:0] out_status;
    logic [cde_pkg::FILL_W-1:0] out_fill;
    logic                       unused_in;

    assign out_item   = m_tdata[ITEM_W-1:0];
    assign out_status = m_tdata[STAT_LO +: cde_pkg::STAT_W];
    assign out_fill   = m_tdata[FILL_LO +: cde_pkg::FILL_W];
    assign unused_in  = s_tvalid & s_tready & (^s_tdata);

    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status == cde_pkg::ST_EMPTY) |->
            (out_item == '1) && (out_fill == '0))
        else $error("empty status without item -1 and fill 0");

    a_overflow_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status == cde_pkg::ST_OVERFLOW) |->
            (out_item == '0) && (out_fill == cde_pkg::FILL_W'(cde_pkg::DEPTH)))
        else $error("overflow reported while not full");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_status == cde_pkg::ST_OK) || (out_status == cde_pkg::ST_OVERFLOW)
                  || (out_status == cde_pkg::ST_EMPTY) || unused_in)
        else $error("undefined status code");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind circular_deque_engine cde_checker u_cde_checker (.*);

`default_nettype wire
